// ===== design/kat_pkg.sv =====
// Shared types and constants for the key access table.
package kat_pkg;

  // Operation codes carried by the opcode field.
  typedef enum logic [1:0] {
    OP_AUTH   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_END    = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_ADMIN = 3'd3,
    ST_OUTSIDE   = 3'd4
  } status_t;

  localparam logic [23:0] DATE_UNSET = 24'hffffff;
  localparam logic [23:0] DATE_ADMIN = 24'heeeeee;

  // Slot indexes travel between modules at the widest supported size.
  localparam int IDX_MAX_W = 8;

  // Outcome of one pass over the table.
  typedef struct packed {
    logic                 found;
    logic [IDX_MAX_W-1:0] match_idx;
    logic [23:0]          match_start;
    logic [23:0]          match_end;
    logic                 free_found;
    logic [IDX_MAX_W-1:0] free_idx;
  } scan_res_t;

endpackage

// ===== design/kat_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module kat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  clk,
  we,
  waddr,
  wdata,
  raddr,
  rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             we;
  input  logic [AW-1:0]    waddr;
  input  logic [WIDTH-1:0] wdata;
  input  logic [AW-1:0]    raddr;
  output logic [WIDTH-1:0] rdata;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/kat_scan.sv =====
// Lookup unit: watches the stream of table entries and keeps the first key match and free slot.
module kat_scan #(
  parameter int IDX_W    = 4,
  parameter int KEY_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  rd_vld,
  input  logic [IDX_W-1:0]      rd_idx,
  input  logic                  rd_live,
  input  logic [KEY_BITS-1:0]   rd_key,
  input  logic [23:0]           rd_start,
  input  logic [23:0]           rd_end,
  input  logic [KEY_BITS-1:0]   key,
  output kat_pkg::scan_res_t    res
);
  import kat_pkg::*;

  logic [KEY_BITS-1:0] eff_key;
  logic [23:0]         eff_start;
  logic [23:0]         eff_end;
  logic                hit;
  logic                free;

  // An entry that was never written or was removed reads as erased.
  assign eff_key   = rd_live ? rd_key   : {KEY_BITS{1'b1}};
  assign eff_start = rd_live ? rd_start : DATE_UNSET;
  assign eff_end   = rd_live ? rd_end   : DATE_UNSET;
  assign hit       = (eff_key == key);
  assign free      = (eff_end == DATE_UNSET);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      res.found      <= 1'b0;
      res.free_found <= 1'b0;
    end else if (rd_vld) begin
      if (hit && !res.found) begin
        res.found       <= 1'b1;
        res.match_idx   <= IDX_MAX_W'(rd_idx);
        res.match_start <= eff_start;
        res.match_end   <= eff_end;
      end
      if (free && !res.free_found) begin
        res.free_found <= 1'b1;
        res.free_idx   <= IDX_MAX_W'(rd_idx);
      end
    end
  end

endmodule

// ===== design/key_access_table_top.sv =====
// Top level of the key access table: sequencer, session state and table memory.
//
// The block keeps a table of SLOTS user keys, each with a valid-from and a
// valid-to date, and a single login session. A transaction is issued by
// raising start with the operation and its fields while busy is low; the
// fields are sampled at that clock edge and busy goes high on the next cycle.
//
// Every transaction reads the whole table once through the single read port
// of the entry memory, one slot per cycle, to find the lowest matching key
// and the lowest free slot. A drain state then empties the read pipeline
// and a finishing state decides the outcome and writes back at most one
// entry. The result appears on the output ports in the cycle after the
// finishing state, marked by done for exactly one cycle. A new transaction
// may be started in that same cycle.
//
// The receiver cannot stall: every result is taken in its done cycle.
//
// Reset clears the session and marks every slot as erased through a row of
// per-slot valid flags, so no clearing pass over the memory is needed and
// the block accepts a transaction in the first cycle after reset.
module key_access_table_top #(
  parameter int SLOTS    = 16,
  parameter int KEY_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [63:0] user_key,
  input  logic [7:0]  start_year,
  input  logic [7:0]  start_month,
  input  logic [7:0]  start_day,
  input  logic [7:0]  end_year,
  input  logic [7:0]  end_month,
  input  logic [7:0]  end_day,
  input  logic [7:0]  now_year,
  input  logic [3:0]  now_month,
  input  logic [4:0]  now_day,
  output logic        done,
  output logic [2:0]  status,
  output logic [3:0]  slot,
  output logic        entry_changed,
  output logic        session_open,
  output logic        session_admin
);
  import kat_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENT_W = KEY_BITS + 48;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;

  // Transaction fields captured at acceptance.
  op_t                 op;
  logic [KEY_BITS-1:0] key;
  logic [23:0]         from_date;
  logic [23:0]         to_date;
  logic [23:0]         now_date;

  // Read pipeline of the table pass.
  logic [IDX_W-1:0] rd_addr;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_live;
  logic [ENT_W-1:0] rd_data;

  // Per-slot written flags; a clear flag means the slot reads as erased.
  logic [SLOTS-1:0] live;

  // Session state. The admin flag always mirrors whether the open session's
  // slot currently holds the admin mark.
  logic             sess_valid;
  logic [IDX_W-1:0] sess_slot;
  logic             sess_admin;

  scan_res_t res;

  // Decision made in the finishing cycle.
  logic             we;
  logic [IDX_W-1:0] widx;
  logic             set_live;
  logic             clr_live;
  status_t          status_next;
  logic [3:0]       slot_next;
  logic             changed_next;
  logic             sess_valid_next;
  logic [IDX_W-1:0] sess_slot_next;
  logic             sess_admin_next;
  logic             ok_from;
  logic             ok_to;

  assign busy = (state != S_IDLE);

  kat_ram #(
    .WIDTH(ENT_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(widx),
    .wdata({key, from_date, to_date}),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  kat_scan #(
    .IDX_W   (IDX_W),
    .KEY_BITS(KEY_BITS)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .clear   (state == S_IDLE),
    .rd_vld  (rd_vld),
    .rd_idx  (rd_idx),
    .rd_live (rd_live),
    .rd_key  (rd_data[ENT_W-1:48]),
    .rd_start(rd_data[47:24]),
    .rd_end  (rd_data[23:0]),
    .key     (key),
    .res     (res)
  );

  // Window test against the matched entry. An unset from-date always passes.
  assign ok_from = (res.match_start == DATE_UNSET) || (res.match_start <= now_date);
  assign ok_to   = (res.match_end >= now_date);

  always_comb begin
    we              = 1'b0;
    widx            = res.match_idx[IDX_W-1:0];
    set_live        = 1'b0;
    clr_live        = 1'b0;
    status_next     = ST_OK;
    slot_next       = 4'd0;
    changed_next    = 1'b0;
    sess_valid_next = sess_valid;
    sess_slot_next  = sess_slot;
    sess_admin_next = sess_admin;
    unique case (op)
      OP_AUTH: begin
        if (!res.found) begin
          status_next = ST_NOT_FOUND;
        end else begin
          slot_next = res.match_idx[3:0];
          if (ok_from && ok_to) begin
            sess_valid_next = 1'b1;
            sess_slot_next  = res.match_idx[IDX_W-1:0];
            sess_admin_next = (res.match_end == DATE_ADMIN);
          end else begin
            sess_valid_next = 1'b0;
            sess_admin_next = 1'b0;
            status_next     = ST_OUTSIDE;
          end
        end
      end
      OP_ADD: begin
        if (!sess_admin) begin
          status_next = ST_NOT_ADMIN;
        end else if (!res.found && !res.free_found) begin
          status_next = ST_FULL;
        end else begin
          if (!res.found) begin
            widx = res.free_idx[IDX_W-1:0];
          end
          we           = 1'b1;
          set_live     = 1'b1;
          changed_next = 1'b1;
          slot_next    = res.found ? res.match_idx[3:0] : res.free_idx[3:0];
          if (sess_slot == widx) begin
            sess_admin_next = (to_date == DATE_ADMIN);
          end
        end
      end
      OP_REMOVE: begin
        if (!sess_admin) begin
          status_next = ST_NOT_ADMIN;
        end else if (!res.found) begin
          status_next = ST_NOT_FOUND;
        end else begin
          // Clearing the written flag erases the entry; the memory is left alone.
          clr_live     = 1'b1;
          changed_next = 1'b1;
          slot_next    = res.match_idx[3:0];
          if (sess_slot == widx) begin
            sess_admin_next = 1'b0;
          end
        end
      end
      OP_END: begin
        sess_valid_next = 1'b0;
        sess_admin_next = 1'b0;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    if (state != S_FINISH) begin
      we       = 1'b0;
      set_live = 1'b0;
      clr_live = 1'b0;
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_addr    <= '0;
      rd_vld     <= 1'b0;
      live       <= '0;
      sess_valid <= 1'b0;
      sess_slot  <= '0;
      sess_admin <= 1'b0;
      done       <= 1'b0;
    end else begin
      // Read data is valid in the cycle after each scan address, and the
      // result is flagged in the cycle after the finishing cycle.
      done   <= (state == S_FINISH);
      rd_vld <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          rd_addr <= '0;
          if (start) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_addr == LAST_IDX) begin
            state <= S_DRAIN;
          end else begin
            rd_addr <= rd_addr + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          state      <= S_IDLE;
          sess_valid <= sess_valid_next;
          sess_slot  <= sess_slot_next;
          sess_admin <= sess_admin_next;
          if (set_live) begin
            live[widx] <= 1'b1;
          end
          if (clr_live) begin
            live[widx] <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: captured fields, read pipeline tags and results.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op        <= op_t'(opcode);
      key       <= user_key[KEY_BITS-1:0];
      from_date <= {start_year, start_month, start_day};
      to_date   <= {end_year, end_month, end_day};
      now_date  <= {now_year, 4'd0, now_month, 3'd0, now_day};
    end
    rd_idx  <= rd_addr;
    rd_live <= live[rd_addr];
    if (state == S_FINISH) begin
      status        <= status_next;
      slot          <= slot_next;
      entry_changed <= changed_next;
      session_open  <= sess_valid_next;
      session_admin <= sess_admin_next;
    end
  end

endmodule
